[hw/rtl/lcs_pkg.sv]
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants of the LCD clock and status sequencer
// Request codes, the request descriptor, the transfer record and the
// configuration record used by the front, the back and the top level.
// ----------------------------------------------------------------------------
package lcs_pkg;

  // Request codes as they arrive on the action field.
  typedef enum logic [1:0] {
    ACT_INIT   = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_NONE   = 2'd3
  } act_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_COMMAND_WAIT = 2'd0,
    REG_DATA_WAIT    = 2'd1,
    REG_CLEAR_EXTRA  = 2'd2,
    REG_POWER_UP     = 2'd3
  } reg_e;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;

  localparam logic [14:0] COMMAND_WAIT_RST = 15'd2000;
  localparam logic [14:0] DATA_WAIT_RST    = 15'd100;
  localparam logic [14:0] CLEAR_EXTRA_RST  = 15'd2000;
  localparam logic [15:0] POWER_UP_RST     = 16'd50000;

  // Power-up nibble waits.
  localparam logic [15:0] NIB1_WAIT = 16'd5000;
  localparam logic [15:0] NIB2_WAIT = 16'd1000;
  localparam logic [15:0] NIB3_WAIT = 16'd1000;

  // Panel commands and nibbles.
  localparam logic [7:0] NIB_WAKE      = 8'h03;
  localparam logic [7:0] NIB_FOUR_BIT  = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_LINE1     = 8'h80;
  localparam logic [7:0] CMD_LINE1_C1  = 8'h81;
  localparam logic [7:0] CMD_LINE1_C3  = 8'h83;
  localparam logic [7:0] CMD_LINE1_C5  = 8'h85;
  localparam logic [7:0] CMD_LINE1_C11 = 8'h8B;
  localparam logic [7:0] CMD_LINE2     = 8'hC0;
  localparam logic [7:0] CMD_LINE2_C7  = 8'hC7;
  localparam logic [7:0] CMD_LINE2_C9  = 8'hC9;
  localparam logic [7:0] CMD_LINE2_C11 = 8'hCB;

  // Index of the final transfer of each request.
  localparam logic [5:0] INIT_LAST   = 6'd7;
  localparam logic [5:0] CLEAR_LAST  = 6'd0;
  localparam logic [5:0] UPDATE_LAST = 6'd34;

  typedef struct packed {
    logic [14:0] command_wait;
    logic [14:0] data_wait;
    logic [14:0] clear_extra;
    logic [15:0] power_up;
  } cfg_t;

  // A request after classification, with its digits worked out.
  typedef struct packed {
    act_e        kind;
    logic        short_hour;
    logic [3:0]  h_ones;
    logic        pm;
    logic [2:0]  m_tens;
    logic [3:0]  m_ones;
    logic        summer;
    logic [5:0]  tenths;
  } desc_t;

  typedef struct packed {
    logic        is_data;
    logic [7:0]  value;
    logic        nibble_only;
    logic [15:0] wait_before;
    logic [15:0] wait_after;
    logic        last;
  } xfer_t;

endpackage

[hw/rtl/lcs_queue.sv]
// ----------------------------------------------------------------------------
// lcs_queue: small first-in first-out queue
// Register-based queue of any packed type; the head entry is always on
// data_o while empty_o is low.
// ----------------------------------------------------------------------------
module lcs_queue #(
  parameter type         T     = logic,
  parameter int unsigned Depth = lcs_pkg::QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  T                store_q [Depth];
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] step_ptr(input logic [PtrW-1:0] p);
    step_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_q];

  always_comb begin
    wr_d  = do_push ? step_ptr(wr_q) : wr_q;
    rd_d  = do_pop  ? step_ptr(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/lcs_front.sv]
// ----------------------------------------------------------------------------
// lcs_front: request classifier
// Decodes the action, converts the hour to 12-hour form, splits the minutes
// into digits and scales the light reading to tenths of a volt.
// ----------------------------------------------------------------------------
module lcs_front (
  input  logic                 req_valid_i,
  input  logic [1:0]           action_i,
  input  logic [4:0]           hours_i,
  input  logic [5:0]           minutes_i,
  input  logic                 summer_time_i,
  input  logic [9:0]           light_reading_i,
  output logic                 desc_valid_o,
  output lcs_pkg::desc_t       desc_o
);
  import lcs_pkg::*;

  logic [4:0]  h12, h12_less10;
  logic        pm;
  logic [13:0] m_mul;
  logic [2:0]  m_tens;
  logic [5:0]  m_ones_full;
  logic [15:0] light_x50;
  logic [5:0]  quot;
  logic [10:0] rem;
  logic [5:0]  tenths;

  always_comb begin
    h12 = hours_i;
    pm  = 1'b0;
    if (hours_i == 5'd0) begin
      h12 = 5'd12;
    end else if (hours_i == 5'd12) begin
      pm = 1'b1;
    end else if (hours_i > 5'd12) begin
      h12 = hours_i - 5'd12;
      pm  = 1'b1;
    end
  end

  assign h12_less10 = h12 - 5'd10;

  // Division by ten as a multiply by 205/2048, exact for these ranges.
  assign m_mul       = {8'b0, minutes_i} * 14'd205;
  assign m_tens      = m_mul[13:11];
  assign m_ones_full = minutes_i - ({3'b0, m_tens} * 6'd10);

  // Divide by 1023 as a divide by 1024 plus one correction step: the true
  // remainder is the low ten bits plus the quotient, always below 2046.
  assign light_x50 = {6'b0, light_reading_i} * 16'd50;
  assign quot      = light_x50[15:10];
  assign rem       = {1'b0, light_x50[9:0]} + {5'b0, quot};
  assign tenths    = quot + {5'b0, (rem >= 11'd1023)};

  always_comb begin
    desc_o.kind       = act_e'(action_i);
    desc_o.short_hour = (h12 < 5'd10);
    desc_o.h_ones     = (h12 < 5'd10) ? h12[3:0] : h12_less10[3:0];
    desc_o.pm         = pm;
    desc_o.m_tens     = m_tens;
    desc_o.m_ones     = m_ones_full[3:0];
    desc_o.summer     = summer_time_i;
    desc_o.tenths     = tenths;
  end

  // The unused action code produces no transfers and is dropped here.
  assign desc_valid_o = req_valid_i && (act_e'(action_i) != ACT_NONE);

endmodule

[hw/rtl/lcs_back.sv]
// ----------------------------------------------------------------------------
// lcs_back: transfer sequencer
// Takes one classified request at a time and steps through its transfers,
// emitting one per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module lcs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lcs_pkg::cfg_t  cfg_i,
  input  lcs_pkg::desc_t desc_i,
  input  logic           desc_empty_i,
  output logic           desc_pop_o,
  output logic           xfer_push_o,
  output lcs_pkg::xfer_t xfer_o,
  input  logic           xfer_full_i
);
  import lcs_pkg::*;

  desc_t       cur_q;
  logic        busy_q, busy_d;
  logic [5:0]  step_q, step_d;
  logic [2:0]  volts_q;
  logic [3:0]  frac_q;
  logic [13:0] v_mul;
  logic [2:0]  volts;
  logic [5:0]  frac_full;
  logic [5:0]  last_step;
  logic        emit, at_last, load;
  logic [15:0] clear_wait;
  xfer_t       x;

  function automatic xfer_t cmd(input logic [7:0] b, input logic [15:0] after);
    xfer_t r;
    r             = '0;
    r.value       = b;
    r.wait_after  = after;
    return r;
  endfunction

  function automatic xfer_t chr(input logic [7:0] b, input logic [15:0] after);
    xfer_t r;
    r             = '0;
    r.is_data     = 1'b1;
    r.value       = b;
    r.wait_after  = after;
    return r;
  endfunction

  function automatic xfer_t nib(input logic [7:0] b, input logic [15:0] after);
    xfer_t r;
    r             = '0;
    r.value       = b;
    r.nibble_only = 1'b1;
    r.wait_after  = after;
    return r;
  endfunction

  function automatic logic [7:0] digit(input logic [3:0] d);
    return 8'h30 + {4'b0, d};
  endfunction

  // Volts and tenths digit are split off as the request is loaded.
  assign v_mul     = {8'b0, desc_i.tenths} * 14'd205;
  assign volts     = v_mul[13:11];
  assign frac_full = desc_i.tenths - ({3'b0, volts} * 6'd10);

  always_comb begin
    unique case (cur_q.kind)
      ACT_INIT:   last_step = INIT_LAST;
      ACT_CLEAR:  last_step = CLEAR_LAST;
      default:    last_step = UPDATE_LAST;
    endcase
  end

  assign emit        = busy_q && !xfer_full_i;
  assign at_last     = (step_q == last_step);
  assign load        = !desc_empty_i && (!busy_q || (emit && at_last));
  assign desc_pop_o  = load;
  assign xfer_push_o = emit;
  assign clear_wait  = {1'b0, cfg_i.command_wait} + {1'b0, cfg_i.clear_extra};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (load) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (emit) begin
      if (at_last) begin
        busy_d = 1'b0;
      end
      step_d = step_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q   <= desc_i;
      volts_q <= volts;
      frac_q  <= frac_full[3:0];
    end
  end

  // Transfer table for the current request and step.
  always_comb begin
    logic [15:0] cw, dw;
    cw = {1'b0, cfg_i.command_wait};
    dw = {1'b0, cfg_i.data_wait};
    x  = '0;
    unique case (cur_q.kind)
      ACT_INIT: begin
        case (step_q)
          6'd0: begin
            x             = nib(NIB_WAKE, NIB1_WAIT);
            x.wait_before = cfg_i.power_up;
          end
          6'd1:    x = nib(NIB_WAKE, NIB2_WAIT);
          6'd2:    x = nib(NIB_WAKE, NIB3_WAIT);
          6'd3:    x = nib(NIB_FOUR_BIT, 16'd0);
          6'd4:    x = cmd(CMD_FUNC_SET, cw);
          6'd5:    x = cmd(CMD_DISP_ON, cw);
          6'd6:    x = cmd(CMD_ENTRY, cw);
          default: x = cmd(CMD_CLEAR, clear_wait);
        endcase
      end
      ACT_CLEAR: x = cmd(CMD_CLEAR, clear_wait);
      default: begin
        case (step_q)
          6'd0:  x = cmd(CMD_LINE1, cw);
          6'd1:  x = cur_q.short_hour ? chr(" ", dw) : cmd(CMD_LINE1, cw);
          6'd2:  x = cur_q.short_hour ? cmd(CMD_LINE1_C1, cw) : chr("1", dw);
          6'd3:  x = chr(digit(cur_q.h_ones), dw);
          6'd4:  x = chr(":", dw);
          6'd5:  x = cmd(CMD_LINE1_C3, cw);
          6'd6:  x = chr(digit({1'b0, cur_q.m_tens}), dw);
          6'd7:  x = chr(digit(cur_q.m_ones), dw);
          6'd8:  x = cmd(CMD_LINE1_C5, cw);
          6'd9:  x = chr(cur_q.pm ? "P" : "A", dw);
          6'd10: x = chr("M", dw);
          6'd11: x = cmd(CMD_LINE1_C11, cw);
          6'd12: x = chr(cur_q.summer ? "S" : "W", dw);
          6'd13: x = chr(cur_q.summer ? "U" : "I", dw);
          6'd14: x = chr(cur_q.summer ? "M" : "N", dw);
          6'd15: x = chr(cur_q.summer ? "R" : "T", dw);
          6'd16: x = cmd(CMD_LINE2, cw);
          6'd17: x = chr("L", dw);
          6'd18: x = chr("i", dw);
          6'd19: x = chr("g", dw);
          6'd20: x = chr("h", dw);
          6'd21: x = chr("t", dw);
          6'd22: x = chr(":", dw);
          6'd23: x = cmd(CMD_LINE2_C7, cw);
          6'd24: x = chr(digit({1'b0, volts_q}), dw);
          6'd25: x = chr(".", dw);
          6'd26: x = cmd(CMD_LINE2_C9, cw);
          6'd27: x = chr(digit(frac_q), dw);
          6'd28: x = chr("V", dw);
          6'd29: x = cmd(CMD_LINE2_C11, cw);
          default: x = chr(" ", dw);
        endcase
      end
    endcase
    x.last = at_last;
  end

  assign xfer_o = x;

endmodule

[hw/rtl/char_lcd_clock_status_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// char_lcd_clock_status_sequencer_unit: character LCD request sequencer
// Expands initialise, clear and update requests into byte-level transfers
// for a downstream 4-bit pin stage, with APB-style wait configuration.
// ----------------------------------------------------------------------------
// Requests are classified on entry and held in a short request queue; a
// sequencer then emits their transfers at one per cycle into a result queue
// while the result queue has room. An initialise request yields 8 transfers,
// a clear request 1 and an update request 35. A new request is taken in
// every cycle while the request queue has room, and a request with the
// unused action code is taken and yields nothing. The final transfer of
// each request carries the last mark.
module char_lcd_clock_status_sequencer_unit #(
  parameter int unsigned QueueDepth = lcs_pkg::QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request side
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  action_i,
  input  logic [4:0]                  hours_i,
  input  logic [5:0]                  minutes_i,
  input  logic                        summer_time_i,
  input  logic [9:0]                  light_reading_i,
  // Transfer side
  output logic                        empty,
  input  logic                        pop,
  output logic                        is_data_o,
  output logic [7:0]                  value_o,
  output logic                        nibble_only_o,
  output logic [15:0]                 wait_before_us_o,
  output logic [15:0]                 wait_after_us_o,
  output logic                        last_o,
  // Configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcs_pkg::APB_AW-1:0]  paddr,
  input  logic [lcs_pkg::APB_DW-1:0]  pwdata,
  output logic [lcs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import lcs_pkg::*;

  cfg_t  cfg_q, cfg_d;
  desc_t front_desc, head_desc;
  logic  front_valid, desc_empty, desc_pop;
  logic  xfer_push, xfer_full;
  xfer_t xfer, out_xfer;
  logic  cfg_write;
  reg_e  reg_sel;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = reg_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (reg_sel)
        REG_COMMAND_WAIT: cfg_d.command_wait = pwdata[14:0];
        REG_DATA_WAIT:    cfg_d.data_wait    = pwdata[14:0];
        REG_CLEAR_EXTRA:  cfg_d.clear_extra  = pwdata[14:0];
        default:          cfg_d.power_up     = pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COMMAND_WAIT: prdata = {17'b0, cfg_q.command_wait};
      REG_DATA_WAIT:    prdata = {17'b0, cfg_q.data_wait};
      REG_CLEAR_EXTRA:  prdata = {17'b0, cfg_q.clear_extra};
      default:          prdata = {16'b0, cfg_q.power_up};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.command_wait <= COMMAND_WAIT_RST;
      cfg_q.data_wait    <= DATA_WAIT_RST;
      cfg_q.clear_extra  <= CLEAR_EXTRA_RST;
      cfg_q.power_up     <= POWER_UP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lcs_front u_front (
    .req_valid_i     (push && !full),
    .action_i        (action_i),
    .hours_i         (hours_i),
    .minutes_i       (minutes_i),
    .summer_time_i   (summer_time_i),
    .light_reading_i (light_reading_i),
    .desc_valid_o    (front_valid),
    .desc_o          (front_desc)
  );

  lcs_queue #(
    .T     (desc_t),
    .Depth (QueueDepth)
  ) u_req_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_desc),
    .full_o  (full),
    .pop_i   (desc_pop),
    .data_o  (head_desc),
    .empty_o (desc_empty)
  );

  lcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .desc_i       (head_desc),
    .desc_empty_i (desc_empty),
    .desc_pop_o   (desc_pop),
    .xfer_push_o  (xfer_push),
    .xfer_o       (xfer),
    .xfer_full_i  (xfer_full)
  );

  lcs_queue #(
    .T     (xfer_t),
    .Depth (QueueDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (xfer_push),
    .data_i  (xfer),
    .full_o  (xfer_full),
    .pop_i   (pop),
    .data_o  (out_xfer),
    .empty_o (empty)
  );

  assign is_data_o        = out_xfer.is_data;
  assign value_o          = out_xfer.value;
  assign nibble_only_o    = out_xfer.nibble_only;
  assign wait_before_us_o = out_xfer.wait_before;
  assign wait_after_us_o  = out_xfer.wait_after;
  assign last_o           = out_xfer.last;

endmodule

[tb/char_lcd_clock_status_sequencer_unit_test.sv]
// ----------------------------------------------------------------------------
// char_lcd_clock_status_sequencer_unit_test: request-to-transfer sequencer test
// Sends initialise, clear, update and unused requests under changing wait
// settings and random stalls on both sides. Every transfer is checked against
// transfers predicted locally from the request and the current register values.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module char_lcd_clock_status_sequencer_unit_test;
  import lcs_pkg::*;

  localparam int unsigned DrainCycles = 120;
  localparam logic [7:0]  DigitZero   = "0";

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [1:0]          action_i;
  logic [4:0]          hours_i;
  logic [5:0]          minutes_i;
  logic                summer_time_i;
  logic [9:0]          light_reading_i;
  logic                empty;
  logic                pop;
  logic                is_data_o;
  logic [7:0]          value_o;
  logic                nibble_only_o;
  logic [15:0]         wait_before_us_o;
  logic [15:0]         wait_after_us_o;
  logic                last_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  cfg_t        wait_cfg;
  xfer_t       expected_transfers[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;

  char_lcd_clock_status_sequencer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .action_i        (action_i),
    .hours_i         (hours_i),
    .minutes_i       (minutes_i),
    .summer_time_i   (summer_time_i),
    .light_reading_i (light_reading_i),
    .empty           (empty),
    .pop             (pop),
    .is_data_o       (is_data_o),
    .value_o         (value_o),
    .nibble_only_o   (nibble_only_o),
    .wait_before_us_o(wait_before_us_o),
    .wait_after_us_o (wait_after_us_o),
    .last_o          (last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("** char_lcd_clock_status_sequencer_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Transfer prediction
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void queue_transfer(logic is_data, logic [7:0] value, logic nibble,
                                         logic [15:0] pre_wait, logic [15:0] after);
    xfer_t t;
    t.is_data     = is_data;
    t.value       = value;
    t.nibble_only = nibble;
    t.wait_before = pre_wait;
    t.wait_after  = after;
    t.last        = 1'b0;
    expected_transfers.push_back(t);
  endfunction

  function automatic void queue_command(logic [7:0] cmd);
    queue_transfer(1'b0, cmd, 1'b0, 16'd0, {1'b0, wait_cfg.command_wait});
  endfunction

  function automatic void queue_char(logic [7:0] ch);
    queue_transfer(1'b1, ch, 1'b0, 16'd0, {1'b0, wait_cfg.data_wait});
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endfunction

  function automatic void predict_transfers(act_e act, logic [4:0] hours, logic [5:0] minutes,
                                            logic summer, logic [9:0] light);
    logic [15:0] clear_wait;
    logic [4:0]  hour12;
    logic        pm;
    int unsigned tenths;
    xfer_t       tail;
    clear_wait = {1'b0, wait_cfg.command_wait} + {1'b0, wait_cfg.clear_extra};
    case (act)
      ACT_INIT: begin
        queue_transfer(1'b0, NIB_WAKE, 1'b1, wait_cfg.power_up, NIB1_WAIT);
        queue_transfer(1'b0, NIB_WAKE, 1'b1, 16'd0, NIB2_WAIT);
        queue_transfer(1'b0, NIB_WAKE, 1'b1, 16'd0, NIB3_WAIT);
        queue_transfer(1'b0, NIB_FOUR_BIT, 1'b1, 16'd0, 16'd0);
        queue_command(CMD_FUNC_SET);
        queue_command(CMD_DISP_ON);
        queue_command(CMD_ENTRY);
        queue_transfer(1'b0, CMD_CLEAR, 1'b0, 16'd0, clear_wait);
      end
      ACT_CLEAR: queue_transfer(1'b0, CMD_CLEAR, 1'b0, 16'd0, clear_wait);
      ACT_UPDATE: begin
        // Hours past 23 fall through to the afternoon branch and show as 12..19 PM.
        hour12 = hours;
        pm     = 1'b0;
        if (hours == 5'd0) begin
          hour12 = 5'd12;
        end else if (hours == 5'd12) begin
          pm = 1'b1;
        end else if (hours > 5'd12) begin
          hour12 = hours - 5'd12;
          pm     = 1'b1;
        end
        tenths = (int'(light) * 50) / 1023;
        queue_command(CMD_LINE1);
        if (hour12 < 5'd10) begin
          queue_char(" ");
          queue_command(CMD_LINE1_C1);
          queue_char(DigitZero + 8'(hour12));
        end else begin
          queue_command(CMD_LINE1);
          queue_char(DigitZero + 8'(hour12 / 10));
          queue_char(DigitZero + 8'(hour12 % 10));
        end
        queue_char(":");
        queue_command(CMD_LINE1_C3);
        queue_char(DigitZero + 8'(minutes / 10));
        queue_char(DigitZero + 8'(minutes % 10));
        queue_command(CMD_LINE1_C5);
        queue_text(pm ? "PM" : "AM");
        queue_command(CMD_LINE1_C11);
        queue_text(summer ? "SUMR" : "WINT");
        queue_command(CMD_LINE2);
        queue_text("Light:");
        queue_command(CMD_LINE2_C7);
        queue_char(DigitZero + 8'(tenths / 10));
        queue_char(".");
        queue_command(CMD_LINE2_C9);
        queue_char(DigitZero + 8'(tenths % 10));
        queue_char("V");
        queue_command(CMD_LINE2_C11);
        queue_text("     ");
      end
      default: ;
    endcase
    if (act != ACT_NONE) begin
      tail = expected_transfers.pop_back();
      tail.last = 1'b1;
      expected_transfers.push_back(tail);
    end
  endfunction

  function automatic logic [31:0] register_value(reg_e idx);
    case (idx)
      REG_COMMAND_WAIT: return {17'd0, wait_cfg.command_wait};
      REG_DATA_WAIT:    return {17'd0, wait_cfg.data_wait};
      REG_CLEAR_EXTRA:  return {17'd0, wait_cfg.clear_extra};
      default:          return {16'd0, wait_cfg.power_up};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------------
  task automatic apb_access(input logic write, input reg_e idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input reg_e idx);
    logic [31:0] got;
    apb_access(1'b0, idx, 32'd0, got);
    compare_field($sformatf("register %s", idx.name()), register_value(idx), got);
  endtask

  task automatic write_register(input reg_e idx, input logic [31:0] data);
    logic [31:0] unused;
    apb_access(1'b1, idx, data, unused);
    case (idx)
      REG_COMMAND_WAIT: wait_cfg.command_wait = data[14:0];
      REG_DATA_WAIT:    wait_cfg.data_wait    = data[14:0];
      REG_CLEAR_EXTRA:  wait_cfg.clear_extra  = data[14:0];
      default:          wait_cfg.power_up     = data[15:0];
    endcase
    check_register(idx);
  endtask

  task automatic write_all_registers(input logic [31:0] data, input logic randomise);
    for (int i = 0; i < 4; i++) write_register(reg_e'(i), randomise ? $urandom() : data);
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic send_request(input act_e act, input logic [4:0] hours,
                              input logic [5:0] minutes, input logic summer,
                              input logic [9:0] light);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push            <= 1'b1;
    action_i        <= act;
    hours_i         <= hours;
    minutes_i       <= minutes;
    summer_time_i   <= summer;
    light_reading_i <= light;
    do @(posedge clk_i); while (full);
    predict_transfers(act, hours, minutes, summer, light);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    act_e        act;
    logic [9:0]  light;
    pick = $urandom_range(99);
    if (pick < 50)      act = ACT_UPDATE;
    else if (pick < 65) act = ACT_INIT;
    else if (pick < 85) act = ACT_CLEAR;
    else                act = ACT_NONE;
    pick = $urandom_range(19);
    if (pick == 0)      light = 10'd0;
    else if (pick == 1) light = 10'd1023;
    else                light = 10'($urandom_range(1023));
    send_request(act, 5'($urandom_range(31)), 6'($urandom_range(63)),
                 1'($urandom_range(1)), light);
  endtask

  // Holds off further requests until every predicted transfer has been taken.
  task automatic hold_requests();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_transfers.size() != 0) @(posedge clk_i);
  endtask

  // An unused request yields nothing, so allow the sequencer time to finish it.
  task automatic settle();
    hold_requests();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Transfer side
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_transfers
    xfer_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_transfers.size() == 0) begin
        $error("transfer with no request outstanding: value 0x%0h", value_o);
        mismatches++;
      end else begin
        want = expected_transfers.pop_front();
        compare_field("is_data", want.is_data, is_data_o);
        compare_field("value", want.value, value_o);
        compare_field("nibble_only", want.nibble_only, nibble_only_o);
        compare_field("wait_before_us", want.wait_before, wait_before_us_o);
        compare_field("wait_after_us", want.wait_after, wait_after_us_o);
        compare_field("last", want.last, last_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_power_on_defaults();
    for (int i = 0; i < 4; i++) check_register(reg_e'(i));
    send_request(ACT_INIT, 5'd0, 6'd0, 1'b0, 10'd0);
    send_request(ACT_CLEAR, 5'd31, 6'd63, 1'b1, 10'd1023);
    send_request(ACT_NONE, 5'd7, 6'd7, 1'b1, 10'd7);
    send_request(ACT_UPDATE, 5'd0, 6'd0, 1'b0, 10'd0);
    send_request(ACT_UPDATE, 5'd1, 6'd5, 1'b1, 10'd1);
    send_request(ACT_UPDATE, 5'd9, 6'd59, 1'b0, 10'd1023);
    send_request(ACT_UPDATE, 5'd10, 6'd60, 1'b1, 10'd511);
    send_request(ACT_UPDATE, 5'd11, 6'd63, 1'b0, 10'd1022);
    send_request(ACT_UPDATE, 5'd12, 6'd30, 1'b1, 10'd21);
    send_request(ACT_UPDATE, 5'd13, 6'd7, 1'b0, 10'd20);
    send_request(ACT_UPDATE, 5'd23, 6'd45, 1'b1, 10'd700);
    send_request(ACT_UPDATE, 5'd24, 6'd0, 1'b0, 10'd1000);
    send_request(ACT_UPDATE, 5'd31, 6'd63, 1'b1, 10'd1023);
    send_request(ACT_NONE, 5'd0, 6'd0, 1'b0, 10'd0);
    send_request(ACT_INIT, 5'd31, 6'd63, 1'b1, 10'd1023);
    send_request(ACT_CLEAR, 5'd0, 6'd0, 1'b0, 10'd0);
  endtask

  task automatic test_wait_extremes();
    settle();
    write_all_registers(32'd0, 1'b0);
    send_request(ACT_INIT, 5'd5, 6'd5, 1'b0, 10'd5);
    send_request(ACT_CLEAR, 5'd5, 6'd5, 1'b0, 10'd5);
    send_request(ACT_UPDATE, 5'd13, 6'd27, 1'b1, 10'd1023);
    settle();
    // All ones, so the bits above each register's width must be dropped.
    write_all_registers(32'hFFFF_FFFF, 1'b0);
    send_request(ACT_INIT, 5'd5, 6'd5, 1'b1, 10'd5);
    send_request(ACT_CLEAR, 5'd5, 6'd5, 1'b1, 10'd5);
    send_request(ACT_UPDATE, 5'd0, 6'd5, 1'b0, 10'd0);
    settle();
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_all_registers(32'd0, 1'b1);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(29) == 0) hold_requests();
      send_random_request();
    end
    settle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    push            = 1'b0;
    action_i        = ACT_NONE;
    hours_i         = '0;
    minutes_i       = '0;
    summer_time_i   = 1'b0;
    light_reading_i = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mismatches      = 0;
    send_idle_pct   = 13;
    recv_idle_pct   = 54;
    wait_cfg.command_wait = COMMAND_WAIT_RST;
    wait_cfg.data_wait    = DATA_WAIT_RST;
    wait_cfg.clear_extra  = CLEAR_EXTRA_RST;
    wait_cfg.power_up     = POWER_UP_RST;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_power_on_defaults();
    test_wait_extremes();
    test_random_traffic(13, 54, 90);
    test_random_traffic(54, 13, 90);
    test_random_traffic(0, 0, 70);

    if (mismatches == 0) begin
      $display("** char_lcd_clock_status_sequencer_unit: PASSED **");
    end else begin
      $display("** char_lcd_clock_status_sequencer_unit: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_queue.sv
hw/rtl/lcs_front.sv
hw/rtl/lcs_back.sv
hw/rtl/char_lcd_clock_status_sequencer_unit.sv
tb/char_lcd_clock_status_sequencer_unit_test.sv
